// ----- hdl/sst_pkg.sv -----
// sst_pkg: request and response item types, query and write structs for the
// slot cell chain, opcode and status codes. No dependencies.
package sst_pkg;

    localparam int NUM_SLOTS = 64;

    localparam int KEY_W = 32;
    localparam int CONN_W = 32;
    localparam int OP_W = 2;
    localparam int ST_W = 2;
    localparam int IDX_W = $clog2(NUM_SLOTS);
    localparam int CNT_W = $clog2(NUM_SLOTS + 1);

    localparam logic [OP_W-1:0] OP_ACCEPT = 2'd0;
    localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

    localparam logic [ST_W-1:0] ST_OK = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL = 2'd1;
    localparam logic [ST_W-1:0] ST_DUP = 2'd2;
    localparam logic [ST_W-1:0] ST_MISS = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]   opcode;
        logic [KEY_W-1:0]  user_id;
        logic [CONN_W-1:0] conn_handle;
    } t_req;

    typedef struct packed {
        logic [ST_W-1:0]   status;
        logic [IDX_W-1:0]  slot_index;
        logic [CONN_W-1:0] released_handle;
        logic [CNT_W-1:0]  active_count;
    } t_rsp;

    // query travelling down the cell chain
    typedef struct packed {
        logic              live;
        logic [KEY_W-1:0]  key;
        logic              hit;
        logic [CONN_W-1:0] conn;
    } t_query;

    // broadcast write to the cells
    typedef struct packed {
        logic              set;
        logic              clr;
        logic [KEY_W-1:0]  key;
        logic [CONN_W-1:0] conn;
    } t_cell_wr;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_COMMIT
    } t_state;

endpackage

// ----- hdl/sst_cell.sv -----
// sst_cell: one slot of the table, holding key, handle and valid bit, and one
// stage of the query chain. Depends on sst_pkg.
module sst_cell #(
    parameter int IDX = 0,
    parameter int IW = 6
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sst_pkg::t_query   i_q,
    input  logic [IW-1:0]     i_q_idx,
    output sst_pkg::t_query   o_q,
    output logic [IW-1:0]     o_q_idx,
    input  sst_pkg::t_cell_wr i_wr,
    input  logic [IW-1:0]     i_wr_idx
);
    import sst_pkg::*;

    localparam logic [IW-1:0] MY_IDX = IW'(IDX);

    logic              r_valid;
    logic [KEY_W-1:0]  r_key;
    logic [CONN_W-1:0] r_conn;
    t_query            r_q;
    logic [IW-1:0]     r_q_idx;
    t_query            n_q;
    logic [IW-1:0]     n_q_idx;
    logic              match;
    logic              sel;

    assign match = r_valid && (r_key == i_q.key);
    assign sel = (i_wr_idx == MY_IDX);

    always_comb begin
        n_q.live = i_q.live;
        n_q.key = i_q.key;
        n_q.hit = i_q.hit || match;
        n_q.conn = i_q.hit ? i_q.conn : r_conn;
        n_q_idx = i_q.hit ? i_q_idx : MY_IDX;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            if (sel && i_wr.set) begin
                r_valid <= 1'b1;
            end else if (sel && i_wr.clr) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_q.live <= i_rst_n && n_q.live;
        r_q.key <= n_q.key;
        r_q.hit <= n_q.hit;
        r_q.conn <= n_q.conn;
        r_q_idx <= n_q_idx;
        if (sel && i_wr.set) begin
            r_key <= i_wr.key;
            r_conn <= i_wr.conn;
        end
    end

    assign o_q = r_q;
    assign o_q_idx = r_q_idx;

endmodule

// ----- hdl/sst_free_list.sv -----
// sst_free_list: FIFO of free slot indices in a memory, with head, tail and
// count; unwritten positions read as their own index. Depends on sst_pkg.
module sst_free_list #(
    parameter int NUM_SLOTS = 64,
    parameter int IW = 6,
    parameter int CW = 7
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_pop,
    input  logic          i_push,
    input  logic [IW-1:0] i_push_idx,
    output logic [IW-1:0] o_head_idx,
    output logic [CW-1:0] o_free_count
);
    import sst_pkg::*;

    localparam logic [IW-1:0] LAST = IW'(NUM_SLOTS - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(NUM_SLOTS);

    logic [IW-1:0] r_mem [NUM_SLOTS];
    logic [IW-1:0] r_head;
    logic [IW-1:0] r_tail;
    logic          r_wrapped;
    logic [CW-1:0] r_count;
    logic [IW-1:0] r_rd;
    logic [IW-1:0] r_head_q;
    logic          r_written;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_wrapped <= 1'b0;
            r_count <= FULL_CNT;
        end else begin
            if (i_pop) begin
                r_head <= (r_head == LAST) ? '0 : r_head + 1'b1;
                r_count <= r_count - 1'b1;
            end else if (i_push && r_count != FULL_CNT) begin
                r_tail <= (r_tail == LAST) ? '0 : r_tail + 1'b1;
                r_count <= r_count + 1'b1;
                if (r_tail == LAST) begin
                    r_wrapped <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && !i_pop && r_count != FULL_CNT) begin
            r_mem[r_tail] <= i_push_idx;
        end
        r_rd <= r_mem[r_head];
        r_head_q <= r_head;
        r_written <= r_wrapped || (r_head < r_tail);
    end

    assign o_head_idx = r_written ? r_rd : r_head_q;
    assign o_free_count = r_count;

endmodule

// ----- hdl/session_slot_table.sv -----
// session_slot_table: session slot pool with a chain of key cells and a FIFO
// free list. Depends on sst_pkg, sst_cell, sst_free_list.
//
//   channel   direction  handshake                  payload
//   request   in         i_req_valid / o_req_ready  i_req (t_req)
//   response  out        o_rsp_valid / i_rsp_ready  o_rsp (t_rsp)
//
// one item at a time; the query walks the cell chain one cell per cycle, from
// acceptance through every cell to the response register
// the next item can be taken once the response is loaded, even if it waits
// a full response register holds the commit until the response is taken
// synchronous active-low reset clears all slots and refills the free list at once
module session_slot_table (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    input  sst_pkg::t_req i_req,
    output logic          o_rsp_valid,
    input  logic          i_rsp_ready,
    output sst_pkg::t_rsp o_rsp
);
    import sst_pkg::*;

    localparam int IW = IDX_W;
    localparam int CW = CNT_W;
    localparam logic [CW-1:0] FULL_CNT = CW'(NUM_SLOTS);

    t_state            r_state;
    t_state            n_state;
    t_req              r_req;
    logic              r_hit;
    logic [IW-1:0]     r_hit_idx;
    logic [CONN_W-1:0] r_hit_conn;
    logic              r_rsp_valid;
    t_rsp              r_rsp;
    t_rsp              n_rsp;

    t_query            chain_q [NUM_SLOTS+1];
    logic [IW-1:0]     chain_idx [NUM_SLOTS+1];
    t_cell_wr          wr;
    logic [IW-1:0]     wr_idx;

    logic              req_fire;
    logic              commit;
    logic              pop;
    logic              push;
    logic [IW-1:0]     head_idx;
    logic [CW-1:0]     free_count;
    logic [CW-1:0]     free_after;

    assign o_req_ready = (r_state == S_IDLE);
    assign req_fire = i_req_valid && o_req_ready;
    assign commit = (r_state == S_COMMIT) && (!r_rsp_valid || i_rsp_ready);

    assign chain_q[0] = '{live: req_fire, key: i_req.user_id, hit: 1'b0, conn: '0};
    assign chain_idx[0] = '0;

    for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
        sst_cell #(
            .IDX (g),
            .IW  (IW)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_q      (chain_q[g]),
            .i_q_idx  (chain_idx[g]),
            .o_q      (chain_q[g+1]),
            .o_q_idx  (chain_idx[g+1]),
            .i_wr     (wr),
            .i_wr_idx (wr_idx)
        );
    end

    sst_free_list #(
        .NUM_SLOTS (NUM_SLOTS),
        .IW        (IW),
        .CW        (CW)
    ) u_free (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pop        (pop),
        .i_push       (push),
        .i_push_idx   (r_hit_idx),
        .o_head_idx   (head_idx),
        .o_free_count (free_count)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (req_fire) begin
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (chain_q[NUM_SLOTS].live) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                if (commit) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        pop = 1'b0;
        push = 1'b0;
        wr.set = 1'b0;
        wr.clr = 1'b0;
        wr.key = r_req.user_id;
        wr.conn = r_req.conn_handle;
        wr_idx = head_idx;
        n_rsp.status = ST_MISS;
        n_rsp.slot_index = '0;
        n_rsp.released_handle = '0;
        unique case (r_req.opcode)
            OP_ACCEPT: begin
                if (free_count == '0) begin
                    n_rsp.status = ST_FULL;
                end else if (r_hit) begin
                    n_rsp.status = ST_DUP;
                end else begin
                    n_rsp.status = ST_OK;
                    n_rsp.slot_index = IDX_W'(head_idx);
                    pop = commit;
                    wr.set = commit;
                end
            end
            OP_RELEASE: begin
                wr_idx = r_hit_idx;
                if (r_hit) begin
                    n_rsp.status = ST_OK;
                    n_rsp.slot_index = IDX_W'(r_hit_idx);
                    n_rsp.released_handle = r_hit_conn;
                    wr.clr = commit;
                    push = commit && (free_count != FULL_CNT);
                end
            end
            OP_LOOKUP: begin
                if (r_hit) begin
                    n_rsp.status = ST_OK;
                    n_rsp.slot_index = IDX_W'(r_hit_idx);
                end
            end
            default: begin
                n_rsp.status = ST_MISS;
            end
        endcase
        free_after = free_count - CW'(pop) + CW'(push);
        n_rsp.active_count = CNT_W'(FULL_CNT - free_after);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (commit) begin
                r_rsp_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_fire) begin
            r_req <= i_req;
        end
        if (r_state == S_SEARCH && chain_q[NUM_SLOTS].live) begin
            r_hit <= chain_q[NUM_SLOTS].hit;
            r_hit_idx <= chain_idx[NUM_SLOTS];
            r_hit_conn <= chain_q[NUM_SLOTS].conn;
        end
        if (commit) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp = r_rsp;

endmodule

// ----- sim/session_slot_table_check.sv -----
// session_slot_table_check: watches the request and response channels, predicts
// each response from its own copy of the slot table and free list, and compares.
// Depends on sst_pkg.
module session_slot_table_check (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    input  logic          i_req_ready,
    input  sst_pkg::t_req i_req,
    input  logic          i_rsp_valid,
    input  logic          i_rsp_ready,
    input  sst_pkg::t_rsp i_rsp,
    output int            o_fail_count,
    output int            o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import sst_pkg::*;

    logic [KEY_W-1:0]  bound_key  [NUM_SLOTS];
    logic [CONN_W-1:0] bound_conn [NUM_SLOTS];
    logic              bound      [NUM_SLOTS];
    logic [IDX_W-1:0]  free_ring  [NUM_SLOTS];
    logic [IDX_W-1:0]  ring_rd;
    logic [IDX_W-1:0]  ring_wr;
    logic [CNT_W-1:0]  free_slots;
    t_rsp              rsp_due [$];
    int                n_fail = 0;

    task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
        n_fail++;
        $display("%0t ns: %s mismatch, expected %0h got %0h", $time, what, want, got);
    endtask

    function automatic logic [IDX_W-1:0] next_pos(logic [IDX_W-1:0] p);
        return (int'(p) == NUM_SLOTS - 1) ? '0 : p + 1'b1;
    endfunction

    // lowest bound slot holding the key, or -1
    function automatic int find_session(logic [KEY_W-1:0] key);
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (bound[i] && bound_key[i] == key) begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic t_rsp serve_request(t_req r);
        t_rsp             res;
        int               hit;
        logic [IDX_W-1:0] s;
        res = '0;
        res.status = ST_MISS;
        case (r.opcode)
            OP_ACCEPT: begin
                if (free_slots == 0) begin
                    res.status = ST_FULL;
                end else if (find_session(r.user_id) >= 0) begin
                    res.status = ST_DUP;
                end else begin
                    s = free_ring[ring_rd];
                    ring_rd = next_pos(ring_rd);
                    free_slots = free_slots - 1'b1;
                    bound_key[s] = r.user_id;
                    bound_conn[s] = r.conn_handle;
                    bound[s] = 1'b1;
                    res.status = ST_OK;
                    res.slot_index = s;
                end
            end
            OP_RELEASE: begin
                hit = find_session(r.user_id);
                if (hit >= 0) begin
                    s = IDX_W'(hit);
                    bound[s] = 1'b0;
                    res.released_handle = bound_conn[s];
                    if (free_slots < NUM_SLOTS) begin
                        free_ring[ring_wr] = s;
                        ring_wr = next_pos(ring_wr);
                        free_slots = free_slots + 1'b1;
                    end
                    res.status = ST_OK;
                    res.slot_index = s;
                end
            end
            OP_LOOKUP: begin
                hit = find_session(r.user_id);
                if (hit >= 0) begin
                    res.status = ST_OK;
                    res.slot_index = IDX_W'(hit);
                end
            end
            default: begin
            end
        endcase
        res.active_count = CNT_W'(NUM_SLOTS - int'(free_slots));
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                bound_key[i] = '0;
                bound_conn[i] = '0;
                bound[i] = 1'b0;
                free_ring[i] = IDX_W'(i);
            end
            ring_rd = '0;
            ring_wr = '0;
            free_slots = CNT_W'(NUM_SLOTS);
            rsp_due.delete();
        end else begin
            if (i_req_valid && i_req_ready) begin
                rsp_due.push_back(serve_request(i_req));
            end
            if (i_rsp_valid && i_rsp_ready) begin
                if (rsp_due.size() == 0) begin
                    report_mismatch("unexpected item, status", '0, 32'(i_rsp.status));
                end else begin
                    want = rsp_due.pop_front();
                    if (i_rsp.status !== want.status) begin
                        report_mismatch("status", 32'(want.status), 32'(i_rsp.status));
                    end
                    if (i_rsp.slot_index !== want.slot_index) begin
                        report_mismatch("slot_index", 32'(want.slot_index),
                                        32'(i_rsp.slot_index));
                    end
                    if (i_rsp.released_handle !== want.released_handle) begin
                        report_mismatch("released_handle", want.released_handle,
                                        i_rsp.released_handle);
                    end
                    if (i_rsp.active_count !== want.active_count) begin
                        report_mismatch("active_count", 32'(want.active_count),
                                        32'(i_rsp.active_count));
                    end
                end
            end
        end
        o_pending <= rsp_due.size();
        o_fail_count <= n_fail;
    end

endmodule

// ----- sim/session_slot_table_test.sv -----
// session_slot_table_test: drives directed and random requests into the slot
// table with random idling on both channels and gives the verdict.
// Depends on sst_pkg, session_slot_table, session_slot_table_check.
module session_slot_table_test;
    timeunit 1ns;
    timeprecision 1ps;
    import sst_pkg::*;

    localparam int SLOTS = NUM_SLOTS;
    localparam int N_RANDOM = 1850;
    localparam int N_IDS = 96;
    localparam int STALL_LIMIT = 2000;
    localparam logic [OP_W-1:0] OP_NONE = 2'd3;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_req_valid = 1'b0;
    t_req i_req = '0;
    logic i_rsp_ready = 1'b0;
    logic o_req_ready;
    logic o_rsp_valid;
    t_rsp o_rsp;

    int fail_count;
    int pending;
    int req_idle_pct = 33;
    int rsp_idle_pct = 33;
    int stall_cycles = 0;
    logic [KEY_W-1:0] id_pool [N_IDS];

    session_slot_table i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req_valid(i_req_valid),
        .o_req_ready(o_req_ready),
        .i_req      (i_req),
        .o_rsp_valid(o_rsp_valid),
        .i_rsp_ready(i_rsp_ready),
        .o_rsp      (o_rsp)
    );

    session_slot_table_check i_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .i_req_ready (o_req_ready),
        .i_req       (i_req),
        .i_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .i_rsp       (o_rsp),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
    end

    always @(posedge i_clk) begin
        if ((i_req_valid && o_req_ready) || (o_rsp_valid && i_rsp_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        while (stall_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("session_slot_table regression: fail");
        $finish;
    end

    task automatic send_req(logic [OP_W-1:0] op, logic [KEY_W-1:0] id,
                            logic [CONN_W-1:0] conn);
        int gap;
        gap = 0;
        if ($urandom_range(99) < req_idle_pct) begin
            gap = ($urandom_range(9) == 0) ? $urandom_range(1, 2 * SLOTS) : $urandom_range(1, 4);
        end
        if (gap > 0) begin
            i_req_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_req_valid <= 1'b1;
        i_req <= t_req'{opcode: op, user_id: id, conn_handle: conn};
        @(posedge i_clk);
        while (!o_req_ready) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        i_req_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin
        int               n_random;
        int               phase;
        int               accept_pct;
        int               release_pct;
        int               pick;
        logic [OP_W-1:0]  op;
        logic [KEY_W-1:0] id;
        for (int i = 0; i < N_IDS; i++) begin
            id_pool[i] = $urandom;
        end
        id_pool[0] = '0;
        id_pool[1] = '1;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_req(OP_LOOKUP, 32'h0000_0000, 32'h0000_0000);
        send_req(OP_RELEASE, 32'hffff_ffff, 32'hffff_ffff);
        send_req(OP_NONE, 32'hffff_ffff, 32'hffff_ffff);
        send_req(OP_ACCEPT, 32'h0000_0000, 32'hffff_ffff);
        send_req(OP_ACCEPT, 32'hffff_ffff, 32'h0000_0000);
        send_req(OP_ACCEPT, 32'h0000_0000, 32'h1234_5678);
        send_req(OP_LOOKUP, 32'hffff_ffff, 32'h0000_0000);
        send_req(OP_LOOKUP, 32'h0000_0000, 32'hffff_ffff);
        send_req(OP_NONE, 32'hffff_ffff, 32'h0000_0000);
        send_req(OP_RELEASE, 32'h0000_0000, 32'h0000_0000);
        send_req(OP_RELEASE, 32'h0000_0000, 32'h0000_0000);
        send_req(OP_LOOKUP, 32'h0000_0000, 32'h0000_0000);
        send_req(OP_ACCEPT, 32'ha5a5_a5a5, 32'h5a5a_5a5a);
        send_req(OP_ACCEPT, 32'h5a5a_5a5a, 32'ha5a5_a5a5);
        send_req(OP_RELEASE, 32'hffff_ffff, 32'hffff_ffff);
        send_req(OP_ACCEPT, 32'h0000_0000, 32'h8000_0001);
        send_req(OP_RELEASE, 32'ha5a5_a5a5, 32'h0000_0000);
        send_req(OP_LOOKUP, 32'h5a5a_5a5a, 32'h0000_0000);
        wait_drained();

        // phases cycle through filling to full, draining and a mix; phase 4 runs without idling
        n_random = 0;
        phase = 0;
        while (n_random < N_RANDOM) begin
            case (phase % 3)
                0: begin
                    accept_pct = 85;
                    release_pct = 5;
                end
                1: begin
                    accept_pct = 15;
                    release_pct = 70;
                end
                default: begin
                    accept_pct = 40;
                    release_pct = 35;
                end
            endcase
            req_idle_pct = (phase == 4) ? 0 : 33;
            rsp_idle_pct = (phase == 4) ? 0 : 33;
            if (phase % 4 == 3) begin
                wait_drained();
            end
            repeat ($urandom_range(100, 170)) begin
                if ($urandom_range(99) < 6) begin
                    op = OP_W'($urandom_range(3));
                    id = $urandom;
                end else begin
                    pick = $urandom_range(99);
                    op = (pick < accept_pct) ? OP_ACCEPT :
                         (pick < accept_pct + release_pct) ? OP_RELEASE : OP_LOOKUP;
                    id = id_pool[$urandom_range(N_IDS - 1)];
                end
                send_req(op, id, $urandom);
                n_random++;
            end
            phase++;
        end

        wait_drained();
        repeat (SLOTS + 16) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("session_slot_table regression: pass");
        end else begin
            $display("session_slot_table regression: fail");
        end
        $finish;
    end

endmodule

// ----- session_slot_table.f -----
hdl/sst_pkg.sv
hdl/sst_cell.sv
hdl/sst_free_list.sv
hdl/session_slot_table.sv
sim/session_slot_table_check.sv
sim/session_slot_table_test.sv
